// ===== hw/rtl/hci_event_packet_parser_unit_macros.svh =====
// Assertion macros shared by the HCI event packet parser RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef HCI_EVENT_PACKET_PARSER_UNIT_MACROS_SVH
`define HCI_EVENT_PACKET_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HEPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hepp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define HEPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hepp next-cycle check failed");

`endif

// ===== hw/rtl/hepp_pkg.sv =====
// Package for the HCI event packet parser: phase and status codes, widths.
// No dependencies; used by the interfaces and all parser modules.
package hepp_pkg;

  // Byte and register widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  // Register indexes (byte address / 4)
  localparam logic [APB_AW-3:0] REG_MAX_PAYLOAD_LEN = '0;

  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd252;

  // H4 packet type bytes
  localparam logic [BYTE_W-1:0] TYPE_COMMAND = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_EVENT   = 8'h04;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_TYPE    = 5'b00001,
    PH_OPCODE  = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  // Per-byte classification
  typedef enum logic [2:0] {
    ST_TYPE_OK  = 3'd0,
    ST_OPCODE   = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_PAYLOAD  = 3'd3,
    ST_CMD_REJ  = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_TOO_LONG = 3'd6
  } status_t;

  // Registered input item handed from the input stage to the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

endpackage

// ===== hw/rtl/hepp_if.sv =====
// Valid/ready channel interfaces for the HCI event packet parser.
// Depends on hepp_pkg for field types.
interface hepp_in_if;
  logic                          valid;
  logic                          ready;
  logic [hepp_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hepp_out_if;
  logic                          valid;
  logic                          ready;
  hepp_pkg::status_t             status;
  logic [hepp_pkg::BYTE_W-1:0]   byte_value;
  logic [hepp_pkg::BYTE_W-1:0]   event_opcode;
  logic [hepp_pkg::BYTE_W-1:0]   payload_len;
  logic [hepp_pkg::BYTE_W-1:0]   payload_index;
  logic                          packet_end;

  modport source (output valid, output status, output byte_value, output event_opcode,
                  output payload_len, output payload_index, output packet_end,
                  input ready);
  modport sink   (input valid, input status, input byte_value, input event_opcode,
                  input payload_len, input payload_index, input packet_end,
                  output ready);
endinterface

// ===== hw/rtl/hepp_in_stage.sv =====
// Input register of the HCI event packet parser: holds one byte for the parser.
// Depends on hepp_pkg and hepp_in_if.
module hepp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  hepp_in_if.sink            in_ch,
  input  logic               take,
  output hepp_pkg::in_item_t item
);
  import hepp_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // Refill when empty or when the parser consumes the held item
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.data_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.data_byte = byte_r;

endmodule

// ===== hw/rtl/hepp_cfg_regs.sv =====
// APB configuration register block: holds the maximum payload length.
// Depends on hepp_pkg.
module hepp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [hepp_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [hepp_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [hepp_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output logic [hepp_pkg::BYTE_W-1:0]  max_len
);
  import hepp_pkg::*;

  logic [BYTE_W-1:0]   max_len_r;
  logic [APB_AW-3:0]   reg_idx;
  logic                wr_max_len;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[APB_AW-1:2];
  assign wr_max_len = cfg_psel && cfg_penable && cfg_pwrite
                      && (reg_idx == REG_MAX_PAYLOAD_LEN);

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (wr_max_len) begin
      max_len_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end

  // Read mux, unmapped addresses read zero
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_MAX_PAYLOAD_LEN) begin
      cfg_prdata = {{(APB_DW-BYTE_W){1'b0}}, max_len_r};
    end
  end

  assign max_len = max_len_r;

endmodule

// ===== hw/rtl/hepp_parser.sv =====
// Phase tracking and classification of one byte, plus the result register.
// Depends on hepp_pkg, hepp_out_if and the assertion macro header.
module hepp_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hepp_pkg::in_item_t           item,
  input  logic [hepp_pkg::BYTE_W-1:0]  max_len,
  output logic                         take,
  hepp_out_if.source                   out_ch
);
  import hepp_pkg::*;
  `include "hci_event_packet_parser_unit_macros.svh"

  // Parse state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] opcode_r, opcode_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] index_r, index_nxt;
  logic              end_r, end_nxt;

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] count_inc;

  // Take the held item whenever the result slot is free or being drained
  assign take      = item.valid && (!out_valid_r || out_ch.ready);
  assign b         = item.data_byte;
  assign count_inc = count_r + 8'd1;

  // Classify the byte and compute the next parse state
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    status_nxt = ST_TYPE_OK;
    index_nxt  = '0;
    end_nxt    = 1'b0;
    unique case (phase_r)
      PH_OPCODE: begin
        opcode_nxt = b;
        status_nxt = ST_OPCODE;
        phase_nxt  = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_nxt = b;
        count_nxt  = '0;
        if (b > max_len) begin
          status_nxt = ST_TOO_LONG;
          phase_nxt  = PH_ERROR;
        end else begin
          status_nxt = ST_LENGTH;
          if (b == '0) begin
            end_nxt   = 1'b1;
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        status_nxt = ST_PAYLOAD;
        index_nxt  = count_r;
        count_nxt  = count_inc;
        if (count_inc >= length_r) begin
          end_nxt   = 1'b1;
          count_nxt = '0;
          phase_nxt = PH_TYPE;
        end
      end
      default: begin
        // type phase, error phase and unused codes all expect a type byte
        count_nxt = '0;
        if (b == TYPE_EVENT) begin
          status_nxt = ST_TYPE_OK;
          opcode_nxt = '0;
          length_nxt = '0;
          phase_nxt  = PH_OPCODE;
        end else begin
          status_nxt = (b == TYPE_COMMAND) ? ST_CMD_REJ : ST_UNKNOWN;
          phase_nxt  = PH_ERROR;
        end
      end
    endcase
  end

  // Output valid: set on load, cleared when drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      opcode_r    <= '0;
      length_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        length_r <= length_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status_nxt;
      byte_r   <= b;
      index_r  <= index_nxt;
      end_r    <= end_nxt;
    end
  end

  // Held opcode/length after the update are reported with the byte
  logic [BYTE_W-1:0] rep_opcode_r;
  logic [BYTE_W-1:0] rep_length_r;
  always_ff @(posedge clk) begin
    if (take) begin
      rep_opcode_r <= opcode_nxt;
      rep_length_r <= length_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.byte_value    = byte_r;
  assign out_ch.event_opcode  = rep_opcode_r;
  assign out_ch.payload_len   = rep_length_r;
  assign out_ch.payload_index = index_r;
  assign out_ch.packet_end    = end_r;

  // A packet only ends on a length or payload byte
  `HEPP_ASSERT_IMP(a_end_status, clk, rst_n, take && end_nxt,
                   status_nxt == ST_LENGTH || status_nxt == ST_PAYLOAD)
  // After a packet end the parser waits for a type byte
  `HEPP_ASSERT_NXT(a_end_to_type, clk, rst_n, take && end_nxt, phase_r == PH_TYPE)
  // Rejections park the parser in the error phase
  `HEPP_ASSERT_NXT(a_reject_err, clk, rst_n,
                   take && (status_nxt == ST_CMD_REJ || status_nxt == ST_UNKNOWN
                            || status_nxt == ST_TOO_LONG),
                   phase_r == PH_ERROR && count_r == '0)
  // A reported payload position always lies inside the payload
  `HEPP_ASSERT_IMP(a_index_range, clk, rst_n, out_valid_r && status_r == ST_PAYLOAD,
                   index_r < rep_length_r)

endmodule

// ===== hw/rtl/hci_event_packet_parser_unit.sv =====
// HCI event packet parser top level: input register, parser, APB config regs.
// Depends on hepp_pkg, hepp_if, hepp_in_stage, hepp_parser and hepp_cfg_regs.
// Accepted bytes pass from the input register into the parser's result register.
// Throughput: one byte per cycle while out_ch.ready is high; the input register and
// the result register each take a new item as soon as the next stage frees or drains.
// Reset (rst_n low, synchronous): phase to type byte, held values zero, max length 252.
module hci_event_packet_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  hepp_in_if.sink                      in_ch,
  hepp_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [hepp_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [hepp_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [hepp_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import hepp_pkg::*;

  in_item_t          item;
  logic              take;
  logic [BYTE_W-1:0] max_len;

  // Input register
  hepp_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  // Configuration registers
  hepp_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  // Parser and result register
  hepp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .max_len (max_len),
    .take    (take),
    .out_ch  (out_ch)
  );

endmodule
